/* rtl/nrch_pkg.sv */
// Shared types and constants for the nearest ray/circle hit unit.
`default_nettype none
package nrch_pkg;
    localparam int COORD_W = 24;
    localparam int RAD_W   = 16;
    localparam int UNIT_W  = 17;
    localparam int IDX_W   = 12;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 3'd4;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [UNIT_W-1:0]  t_unit;
endpackage
`default_nettype wire

/* rtl/nearest_ray_circle_hit_unit.sv */
// Top level: nearest ray/circle hit search over a stream of targets on one shared multiplier.
//  channel | direction | handshake              | payload
//  target  | in        | i_valid / o_ready      | i_target_x/_y/_radius/_active, i_last_target
//  result  | out       | o_valid / i_ready      | o_hit, o_hit_index, o_hit_distance
//  config  | in        | i_cfg_we (no wait)     | i_cfg_idx, i_cfg_data
// A target is skipped, rejected by projection or fully tested; the single 27x27 multiplier
// steps through the dot and offset products in turn.
// The first target of a scan first normalizes the direction: two squares, a 32-step square
// root and two 17-step divides, the divides skipped for a zero direction. Reset is synchronous;
// the result sits in an output register, and a last target stalls only while the previous result has not been taken.
`default_nettype none
module nearest_ray_circle_hit_unit
    import nrch_pkg::*;
#(
    parameter int MAX_TARGETS = 4096
)(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [COORD_W-1:0]   i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire t_coord               i_target_x,
    input  wire t_coord               i_target_y,
    input  wire logic [RAD_W-1:0]     i_target_radius,
    input  wire logic                 i_target_active,
    input  wire logic                 i_last_target,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_hit,
    output logic [IDX_W-1:0]          o_hit_index,
    output logic [COORD_W-1:0]        o_hit_distance
);
    localparam int CW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_NSQX = 4'd1;
    localparam logic [3:0] ST_NSQY = 4'd2;
    localparam logic [3:0] ST_NGO  = 4'd3;
    localparam logic [3:0] ST_NWT  = 4'd4;
    localparam logic [3:0] ST_USE  = 4'd5;
    localparam logic [3:0] ST_M1   = 4'd6;
    localparam logic [3:0] ST_M2   = 4'd7;
    localparam logic [3:0] ST_CHK  = 4'd8;
    localparam logic [3:0] ST_M3   = 4'd9;
    localparam logic [3:0] ST_M4   = 4'd10;
    localparam logic [3:0] ST_M5   = 4'd11;
    localparam logic [3:0] ST_M6   = 4'd12;
    localparam logic [3:0] ST_M7   = 4'd13;
    localparam logic [3:0] ST_M8   = 4'd14;
    localparam logic [3:0] ST_FIN  = 4'd15;

    t_coord r_ox, r_oy, r_dx, r_dy;
    logic [COORD_W-1:0] r_maxd;

    logic [3:0]          r_state;
    logic signed [26:0]  r_rx, r_ry, r_ex, r_ey;
    logic [RAD_W-1:0]    r_rad;
    logic                r_active, r_last;
    logic signed [55:0]  r_acc;
    logic signed [53:0]  r_prod;
    logic [COORD_W-1:0]  r_proj;
    t_unit               r_ux, r_uy;
    logic                r_started;
    logic [CW-1:0]       r_cnt, r_best_idx;
    logic                r_best_found;
    logic [COORD_W-1:0]  r_best_dist;
    logic                r_out_valid, r_out_hit;
    logic [IDX_W-1:0]    r_out_idx;
    logic [COORD_W-1:0]  r_out_dist;

    logic signed [26:0] mul_a, mul_b;
    logic signed [53:0] prod;
    logic               norm_start, norm_done;
    t_unit              norm_ux, norm_uy;
    logic               in_acc;
    logic               out_load;
    logic [16:0]        best_ext;

    function automatic logic signed [26:0] trunc15(input logic signed [53:0] p);
        logic signed [53:0] t;
        t = p + (p[53] ? 54'sd32767 : 54'sd0);
        return 27'(t >>> 15);
    endfunction

    nrch_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_n     ({r_acc[47:0], 16'b0}),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .o_done  (norm_done),
        .o_ux    (norm_ux),
        .o_uy    (norm_uy)
    );

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_NSQX: begin mul_a = 27'(r_dx); mul_b = 27'(r_dx); end
            ST_NSQY: begin mul_a = 27'(r_dy); mul_b = 27'(r_dy); end
            ST_M1:   begin mul_a = r_rx; mul_b = 27'(r_ux); end
            ST_M2:   begin mul_a = r_ry; mul_b = 27'(r_uy); end
            ST_M3:   begin mul_a = 27'(r_ux); mul_b = $signed({3'b000, r_proj}); end
            ST_M4:   begin mul_a = 27'(r_uy); mul_b = $signed({3'b000, r_proj}); end
            ST_M6:   begin mul_a = r_ex; mul_b = r_ex; end
            ST_M7:   begin mul_a = r_ey; mul_b = r_ey; end
            ST_M8:   begin
                mul_a = $signed({11'b0, r_rad});
                mul_b = $signed({11'b0, r_rad});
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        prod = mul_a * mul_b;
    end

    assign o_ready    = (r_state == ST_IDLE);
    assign in_acc     = i_valid && o_ready;
    assign norm_start = (r_state == ST_NGO);
    assign out_load   = (r_state == ST_FIN) && r_last && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox   <= '0;
            r_oy   <= '0;
            r_dx   <= '0;
            r_dy   <= '0;
            r_maxd <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORIGIN_X: r_ox   <= i_cfg_data;
                CFG_ORIGIN_Y: r_oy   <= i_cfg_data;
                CFG_DIR_X:    r_dx   <= i_cfg_data;
                CFG_DIR_Y:    r_dy   <= i_cfg_data;
                CFG_MAX_DIST: r_maxd <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ux         <= '0;
            r_uy         <= '0;
            r_started    <= 1'b0;
            r_cnt        <= '0;
            r_best_found <= 1'b0;
            r_best_idx   <= '0;
            r_best_dist  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_state   <= r_started ? ST_USE : ST_NSQX;
                        r_started <= 1'b1;
                    end
                end
                ST_NSQX: begin
                    r_acc   <= 56'(prod);
                    r_state <= ST_NSQY;
                end
                ST_NSQY: begin
                    r_acc   <= r_acc + 56'(prod);
                    r_state <= ST_NGO;
                end
                ST_NGO: r_state <= ST_NWT;
                ST_NWT: begin
                    if (norm_done) begin
                        r_ux    <= norm_ux;
                        r_uy    <= norm_uy;
                        r_state <= ST_USE;
                    end
                end
                ST_USE: begin
                    if (r_active && r_rad != '0 && r_maxd != '0 &&
                        (r_ux != '0 || r_uy != '0)) begin
                        r_state <= ST_M1;
                    end else begin
                        r_state <= ST_FIN;
                    end
                end
                ST_M1: begin
                    r_acc   <= 56'(prod);
                    r_state <= ST_M2;
                end
                ST_M2: begin
                    r_acc   <= r_acc + 56'(prod);
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    if (r_acc[55] || (r_acc[54:15] > {16'b0, r_maxd})) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_proj  <= r_acc[38:15];
                        r_state <= ST_M3;
                    end
                end
                ST_M3: begin
                    r_prod  <= prod;
                    r_state <= ST_M4;
                end
                ST_M4: begin
                    r_ex    <= r_rx - trunc15(r_prod);
                    r_prod  <= prod;
                    r_state <= ST_M5;
                end
                ST_M5: begin
                    r_ey    <= r_ry - trunc15(r_prod);
                    r_state <= ST_M6;
                end
                ST_M6: begin
                    r_acc   <= 56'(prod);
                    r_state <= ST_M7;
                end
                ST_M7: begin
                    r_acc   <= r_acc + 56'(prod);
                    r_state <= ST_M8;
                end
                ST_M8: begin
                    if (r_acc <= 56'(prod) && (!r_best_found || r_proj < r_best_dist)) begin
                        r_best_found <= 1'b1;
                        r_best_idx   <= r_cnt;
                        r_best_dist  <= r_proj;
                    end
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (r_last) begin
                        if (out_load) begin
                            r_out_valid  <= 1'b1;
                            r_out_hit    <= r_best_found;
                            r_out_idx    <= r_best_found ? best_ext[IDX_W-1:0] : '0;
                            r_out_dist   <= r_best_found ? r_best_dist : '0;
                            r_started    <= 1'b0;
                            r_cnt        <= '0;
                            r_best_found <= 1'b0;
                            r_best_idx   <= '0;
                            r_best_dist  <= '0;
                            r_state      <= ST_IDLE;
                        end
                    end else begin
                        if (r_cnt < CW'(MAX_TARGETS - 1)) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rx     <= 27'(i_target_x) - 27'(r_ox);
            r_ry     <= 27'(i_target_y) - 27'(r_oy);
            r_rad    <= i_target_radius;
            r_active <= i_target_active;
            r_last   <= i_last_target;
        end
    end

    assign best_ext       = 17'(r_best_idx);
    assign o_valid        = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_hit_index    = r_out_idx;
    assign o_hit_distance = r_out_dist;

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_hit_index == '0 && o_hit_distance == '0)
        else $error("miss result carries nonzero payload");

    a_best_le_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_found |-> r_best_idx <= r_cnt)
        else $error("best index beyond target count");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_ready)
        else $error("ready after accepting a target");

    a_norm_only_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        norm_start |-> r_started)
        else $error("normalization outside a scan");
endmodule
`default_nettype wire

/* rtl/nrch_norm.sv */
// Iterative square root and divider that turns a direction into a Q1.15 unit vector.
`default_nettype none
module nrch_norm
    import nrch_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_n,
    input  wire t_coord      i_dx,
    input  wire t_coord      i_dy,
    output logic             o_done,
    output t_unit            o_ux,
    output t_unit            o_uy
);
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SQRT = 2'd1;
    localparam logic [1:0] PH_DIVX = 2'd2;
    localparam logic [1:0] PH_DIVY = 2'd3;

    logic [1:0]  r_ph, n_ph;
    logic [4:0]  r_cnt, n_cnt;
    logic [63:0] r_n, n_n;
    logic [35:0] r_rem, n_rem;
    logic [31:0] r_root, n_root;
    logic [32:0] r_drem, n_drem;
    logic [16:0] r_q, n_q;
    t_unit       r_ux, n_ux, r_uy, n_uy;
    logic        r_done, n_done;

    logic [35:0] sq_rem;
    logic [35:0] sq_trial;
    logic [32:0] d_rem;
    logic [23:0] mag_x, mag_y;
    logic [16:0] q_next;
    logic        q_bit;

    always_comb begin
        mag_x    = i_dx[23] ? 24'(-i_dx) : 24'(i_dx);
        mag_y    = i_dy[23] ? 24'(-i_dy) : 24'(i_dy);
        sq_rem   = {r_rem[33:0], r_n[63:62]};
        sq_trial = {2'b00, r_root, 2'b01};
        d_rem    = {r_drem[31:0], 1'b0};
        q_bit    = d_rem >= {1'b0, r_root};
        q_next   = {r_q[15:0], q_bit};
    end

    always_comb begin
        n_ph   = r_ph;
        n_cnt  = r_cnt;
        n_n    = r_n;
        n_rem  = r_rem;
        n_root = r_root;
        n_drem = r_drem;
        n_q    = r_q;
        n_ux   = r_ux;
        n_uy   = r_uy;
        n_done = 1'b0;
        case (r_ph)
            PH_IDLE: begin
                if (i_start) begin
                    n_ph   = PH_SQRT;
                    n_cnt  = 5'd31;
                    n_n    = i_n;
                    n_rem  = '0;
                    n_root = '0;
                end
            end
            PH_SQRT: begin
                n_n = {r_n[61:0], 2'b00};
                if (sq_rem >= sq_trial) begin
                    n_rem  = sq_rem - sq_trial;
                    n_root = {r_root[30:0], 1'b1};
                end else begin
                    n_rem  = sq_rem;
                    n_root = {r_root[30:0], 1'b0};
                end
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    if ({r_root[30:0], n_root[0]} == 32'd0) begin
                        n_ux   = '0;
                        n_uy   = '0;
                        n_done = 1'b1;
                        n_ph   = PH_IDLE;
                    end else begin
                        n_ph   = PH_DIVX;
                        n_cnt  = 5'd16;
                        n_drem = {3'b000, mag_x, 6'b0};
                        n_q    = '0;
                    end
                end
            end
            PH_DIVX, PH_DIVY: begin
                n_drem = q_bit ? d_rem - {1'b0, r_root} : d_rem;
                n_q    = q_next;
                n_cnt  = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    if (r_ph == PH_DIVX) begin
                        n_ux   = i_dx[23] ? -$signed(q_next) : $signed(q_next);
                        n_ph   = PH_DIVY;
                        n_cnt  = 5'd16;
                        n_drem = {3'b000, mag_y, 6'b0};
                        n_q    = '0;
                    end else begin
                        n_uy   = i_dy[23] ? -$signed(q_next) : $signed(q_next);
                        n_ph   = PH_IDLE;
                        n_done = 1'b1;
                    end
                end
            end
            default: n_ph = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_IDLE;
            r_done <= 1'b0;
        end else begin
            r_ph   <= n_ph;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_n    <= n_n;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_drem <= n_drem;
        r_q    <= n_q;
        r_ux   <= n_ux;
        r_uy   <= n_uy;
    end

    assign o_done = r_done;
    assign o_ux   = r_ux;
    assign o_uy   = r_uy;
endmodule
`default_nettype wire

/* tb/nrch_checker.sv */
// Checker for the nearest ray/circle hit unit: predicts each scan result and compares it.
`default_nettype none
module nrch_checker
    import nrch_pkg::*;
#(
    parameter int MAX_TARGETS = 4096
)(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [COORD_W-1:0]   i_cfg_data,
    input  wire logic                 i_tgt_valid,
    input  wire logic                 i_tgt_ready,
    input  wire logic [COORD_W-1:0]   i_tgt_x,
    input  wire logic [COORD_W-1:0]   i_tgt_y,
    input  wire logic [RAD_W-1:0]     i_tgt_radius,
    input  wire logic                 i_tgt_active,
    input  wire logic                 i_tgt_last,
    input  wire logic                 i_res_valid,
    input  wire logic                 i_res_ready,
    input  wire logic                 i_hit,
    input  wire logic [IDX_W-1:0]     i_hit_index,
    input  wire logic [COORD_W-1:0]   i_hit_distance,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_scans,
    output int                        o_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic             hit;
        logic [IDX_W-1:0] index;
        logic [COORD_W-1:0] distance;
    } t_scan_hit;

    t_scan_hit expected_hits[$];

    longint org_x, org_y, dir_x, dir_y, max_dist;
    longint unit_x, unit_y, best_dist;
    bit     scan_open, best_found;
    int     tgt_count, best_idx;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, t, b;
        r = 0;
        b = 64'd1 << 31;
        while (b != 0) begin
            t = r | b;
            if (t * t <= n)
                r = t;
            b >>= 1;
        end
        return r;
    endfunction

    function automatic longint div_toward_zero15(longint v);
        if (v < 0)
            return -((-v) >> 15);
        return v >> 15;
    endfunction

    function automatic longint unit_component(longint d, longint unsigned len);
        longint unsigned mag;
        longint q;
        mag = (d < 0) ? -d : d;
        q = (mag << 23) / len;
        return (d < 0) ? -q : q;
    endfunction

    task automatic latch_direction();
        longint unsigned ax, ay, len;
        ax = (dir_x < 0) ? -dir_x : dir_x;
        ay = (dir_y < 0) ? -dir_y : dir_y;
        len = int_sqrt((ax * ax + ay * ay) << 16);
        if (len == 0) begin
            unit_x = 0;
            unit_y = 0;
        end else begin
            unit_x = unit_component(dir_x, len);
            unit_y = unit_component(dir_y, len);
        end
    endtask

    task automatic score_target();
        longint rx, ry, dot, proj, ex, ey, off2, rad;
        t_scan_hit rec;
        rad = i_tgt_radius;
        if (!scan_open) begin
            latch_direction();
            scan_open = 1;
        end
        if (i_tgt_active && rad != 0 && max_dist != 0 && (unit_x != 0 || unit_y != 0)) begin
            rx = longint'($signed(i_tgt_x)) - org_x;
            ry = longint'($signed(i_tgt_y)) - org_y;
            dot = rx * unit_x + ry * unit_y;
            if (dot >= 0) begin
                proj = dot >> 15;
                if (proj <= max_dist) begin
                    ex = rx - div_toward_zero15(unit_x * proj);
                    ey = ry - div_toward_zero15(unit_y * proj);
                    off2 = ex * ex + ey * ey;
                    if (off2 <= rad * rad && (!best_found || proj < best_dist)) begin
                        best_found = 1;
                        best_idx = tgt_count;
                        best_dist = proj;
                    end
                end
            end
        end
        if (tgt_count < MAX_TARGETS - 1)
            tgt_count++;
        if (i_tgt_last) begin
            rec.hit = best_found;
            rec.index = best_found ? best_idx[IDX_W-1:0] : '0;
            rec.distance = best_found ? best_dist[COORD_W-1:0] : '0;
            expected_hits = {expected_hits, rec};
            o_scans++;
            if (best_found)
                o_hits++;
            scan_open = 0;
            tgt_count = 0;
            best_found = 0;
            best_idx = 0;
            best_dist = 0;
        end
    endtask

    task automatic compare_result();
        t_scan_hit rec;
        if (expected_hits.size() == 0) begin
            $error("unexpected result transaction: hit=%0d index=%0d distance=%0d",
                i_hit, i_hit_index, i_hit_distance);
            o_errors++;
        end else begin
            rec = expected_hits.pop_front();
            if (i_hit !== rec.hit) begin
                $error("hit: expected %0d, actual %0d", rec.hit, i_hit);
                o_errors++;
            end
            if (i_hit_index !== rec.index) begin
                $error("hit_index: expected %0d, actual %0d", rec.index, i_hit_index);
                o_errors++;
            end
            if (i_hit_distance !== rec.distance) begin
                $error("hit_distance: expected %0d, actual %0d", rec.distance, i_hit_distance);
                o_errors++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            org_x = 0; org_y = 0; dir_x = 0; dir_y = 0; max_dist = 0;
            unit_x = 0; unit_y = 0;
            scan_open = 0; tgt_count = 0; best_found = 0; best_idx = 0; best_dist = 0;
            expected_hits.delete();
        end else begin
            if (i_res_valid && i_res_ready)
                compare_result();
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ORIGIN_X: org_x = longint'($signed(i_cfg_data));
                    CFG_ORIGIN_Y: org_y = longint'($signed(i_cfg_data));
                    CFG_DIR_X:    dir_x = longint'($signed(i_cfg_data));
                    CFG_DIR_Y:    dir_y = longint'($signed(i_cfg_data));
                    CFG_MAX_DIST: max_dist = longint'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_tgt_valid && i_tgt_ready)
                score_target();
        end
        o_pending = expected_hits.size();
    end
endmodule
`default_nettype wire

/* tb/nearest_ray_circle_hit_unit_test.sv */
// Testbench top for the nearest ray/circle hit unit: stimulus, idling and verdict.
`default_nettype none
module nearest_ray_circle_hit_unit_test
    import nrch_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 2000000;

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [COORD_W-1:0]   i_cfg_data = '0;
    logic                 i_valid = 0;
    logic                 o_ready;
    logic [COORD_W-1:0]   i_target_x = '0;
    logic [COORD_W-1:0]   i_target_y = '0;
    logic [RAD_W-1:0]     i_target_radius = '0;
    logic                 i_target_active = 0;
    logic                 i_last_target = 0;
    logic                 o_valid;
    logic                 i_ready = 0;
    logic                 o_hit;
    logic [IDX_W-1:0]     o_hit_index;
    logic [COORD_W-1:0]   o_hit_distance;

    int     errors, pending, scans, hits;
    longint cycles = 0;
    bit     calm = 0;
    longint cur_ox, cur_oy, cur_dx, cur_dy, cur_max;

    nearest_ray_circle_hit_unit u_dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .o_ready, .i_target_x, .i_target_y, .i_target_radius,
        .i_target_active, .i_last_target,
        .o_valid, .i_ready, .o_hit, .o_hit_index, .o_hit_distance
    );

    nrch_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_tgt_valid(i_valid), .i_tgt_ready(o_ready),
        .i_tgt_x(i_target_x), .i_tgt_y(i_target_y), .i_tgt_radius(i_target_radius),
        .i_tgt_active(i_target_active), .i_tgt_last(i_last_target),
        .i_res_valid(o_valid), .i_res_ready(i_ready),
        .i_hit(o_hit), .i_hit_index(o_hit_index), .i_hit_distance(o_hit_distance),
        .o_errors(errors), .o_pending(pending), .o_scans(scans), .o_hits(hits)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge i_clk)
        i_ready <= calm || ($urandom_range(99) >= 36);

    task automatic send_target(longint x, longint y, int radius, bit active, bit last);
        while (!calm && $urandom_range(99) < 36) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_target_x <= x[COORD_W-1:0];
        i_target_y <= y[COORD_W-1:0];
        i_target_radius <= radius[RAD_W-1:0];
        i_target_active <= active;
        i_last_target <= last;
        i_valid <= 1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // drain outstanding scans, then let the last skipped targets finish
    task automatic settle();
        i_valid <= 0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic set_ray(longint ox, longint oy, longint dx, longint dy, longint md);
        settle();
        cur_ox = ox; cur_oy = oy; cur_dx = dx; cur_dy = dy; cur_max = md;
        i_cfg_we <= 1;
        i_cfg_idx <= CFG_ORIGIN_X; i_cfg_data <= ox[COORD_W-1:0]; @(negedge i_clk);
        i_cfg_idx <= CFG_ORIGIN_Y; i_cfg_data <= oy[COORD_W-1:0]; @(negedge i_clk);
        i_cfg_idx <= CFG_DIR_X;    i_cfg_data <= dx[COORD_W-1:0]; @(negedge i_clk);
        i_cfg_idx <= CFG_DIR_Y;    i_cfg_data <= dy[COORD_W-1:0]; @(negedge i_clk);
        i_cfg_idx <= CFG_MAX_DIST; i_cfg_data <= md[COORD_W-1:0]; @(negedge i_clk);
        i_cfg_we <= 0;
        @(negedge i_clk);
    endtask

    function automatic longint pick_signed(int span_bits);
        longint v;
        v = $urandom_range(0, (1 << span_bits) - 1);
        return v - (1 << (span_bits - 1));
    endfunction

    task automatic random_target(bit last);
        longint k, x, y;
        int r;
        if ($urandom_range(99) < 15) begin
            send_target($urandom, $urandom, $urandom_range(0, 65535), $urandom_range(1), last);
        end else begin
            k = $urandom_range(0, 1023);
            r = $urandom_range(1, 4095);
            x = cur_ox + ((cur_dx * k) >>> 8) + $urandom_range(0, 2 * r) - r;
            y = cur_oy + ((cur_dy * k) >>> 8) + $urandom_range(0, 2 * r) - r;
            if ($urandom_range(19) == 0)
                r = 0;
            send_target(x, y, r, $urandom_range(9) != 0, last);
        end
    endtask

    task automatic random_phase(int n_items);
        int sent, len;
        longint ox, oy, dx, dy, md;
        ox = ($urandom_range(5) == 0) ? pick_signed(24) : pick_signed(18);
        oy = ($urandom_range(5) == 0) ? pick_signed(24) : pick_signed(18);
        dx = ($urandom_range(5) == 0) ? pick_signed(24) : pick_signed(13);
        dy = ($urandom_range(5) == 0) ? pick_signed(24) : pick_signed(13);
        if ($urandom_range(15) == 0) begin
            dx = 0;
            dy = 0;
        end
        case ($urandom_range(5))
            0: md = 0;
            1: md = 24'hFFFFFF;
            default: md = $urandom_range(1, 24'hFFFFFF);
        endcase
        set_ray(ox, oy, dx, dy, md);
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                random_target(i == len - 1);
            sent += len;
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // along +x, max 512.0: hit, tie, behind, beyond, skipped, extremes
        set_ray(0, 0, 256, 0, 'h20000);
        send_target(2560, 100, 256, 1, 0);
        send_target(2560, -100, 256, 1, 0);
        send_target(1280, 0, 0, 1, 0);
        send_target(512, 0, 256, 0, 0);
        send_target(-2560, 0, 256, 1, 0);
        send_target('h30000, 0, 256, 1, 0);
        send_target('h7FFFFF, 'h7FFFFF, 'hFFFF, 1, 0);
        send_target(-'h800000, -'h800000, 'hFFFF, 1, 0);
        send_target(1024, 5000, 1, 1, 1);
        send_target(0, 0, 0, 0, 1);
        set_ray(100, -100, 0, 0, 'hFFFFFF);
        send_target(100, -100, 'hFFFF, 1, 0);
        send_target(2000, -100, 'hFFFF, 1, 1);
        set_ray(0, 0, 1, 0, 0);
        send_target(256, 0, 'hFFFF, 1, 1);
        set_ray(-'h800000, 'h7FFFFF, -'h800000, 'h7FFFFF, 'hFFFFFF);
        send_target(-'h800000, 'h7FFFFF, 'hFFFF, 1, 0);
        send_target('h7FFFFF, -'h800000, 'hFFFF, 1, 0);
        send_target(-'h800100, 'h7FFF00, 'h100, 1, 1);

        // one long scan with a single active target near its end
        calm = 1;
        set_ray(0, 0, 256, 0, 'hFFFFFF);
        for (int i = 0; i < 200; i++)
            send_target(2560, 0, 256, i == 198, i == 199);
        calm = 0;

        for (int p = 0; p < 11; p++) begin
            calm = (p == 5);
            random_phase(155);
        end
        calm = 0;

        settle();
        $display("Covered %0d scans (%0d with a hit) across directed and random ray setups.",
            scans, hits);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
